@@ design/mbq_pkg.sv @@
`default_nettype none

package mbq_pkg;

  localparam int SampleBits  = 24;
  localparam int MaxChannels = 8;
  localparam int ChanBits    = 3;
  localparam int CoefBits    = 32;
  localparam int StBits      = 48;
  localparam int YSplit      = 24;
  localparam int MulBBits    = (SampleBits > YSplit + 1) ? SampleBits : YSplit + 1;
  localparam int ProdBits    = CoefBits + MulBBits;
  localparam int AccBits     = 56;
  localparam int CombBits    = ProdBits + YSplit;
  localparam int FbShift     = 30;
  localparam int PShift      = SampleBits - 11;
  localparam int OShift      = 41 - SampleBits;
  localparam int RegIdxBits  = 3;

  localparam logic signed [AccBits-1:0] StMaxAcc =
    {{(AccBits-StBits+1){1'b0}}, {(StBits-1){1'b1}}};
  localparam logic signed [AccBits-1:0] StMinAcc = ~StMaxAcc;
  localparam logic signed [StBits:0] RndHalf = (StBits+1)'(1) << (OShift - 1);
  localparam logic signed [StBits:0] OutMax =
    {{(StBits-SampleBits+2){1'b0}}, {(SampleBits-1){1'b1}}};
  localparam logic signed [StBits:0] OutMin = ~OutMax;

  localparam logic signed [CoefBits-1:0] CoefOne = CoefBits'(32'h4000_0000);

  typedef enum logic [RegIdxBits-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B1,
    ST_B2,
    ST_A1H,
    ST_A1L,
    ST_A2H,
    ST_A2L,
    ST_FIN,
    ST_WR
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_B1,
    OP_B2,
    OP_A1H,
    OP_A1L,
    OP_A2H,
    OP_A2L,
    OP_FIN,
    OP_WR
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  typedef struct packed {
    logic signed [CoefBits-1:0] b0;
    logic signed [CoefBits-1:0] b1;
    logic signed [CoefBits-1:0] b2;
    logic signed [CoefBits-1:0] a1;
    logic signed [CoefBits-1:0] a2;
  } coef_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_in;
    logic [ChanBits-1:0]          chan;
    logic                         restart;
  } in_req_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_out;
    logic [ChanBits-1:0]          chan_out;
    logic                         clipped;
  } out_req_t;

  typedef struct packed {
    logic                     clip;
    logic signed [StBits-1:0] val;
  } sat_t;

  function automatic sat_t sat_st(input logic signed [AccBits-1:0] v);
    sat_t r;
    r.clip = 1'b0;
    r.val  = v[StBits-1:0];
    if (v > StMaxAcc) begin
      r.clip = 1'b1;
      r.val  = StMaxAcc[StBits-1:0];
    end else if (v < StMinAcc) begin
      r.clip = 1'b1;
      r.val  = StMinAcc[StBits-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [AccBits-1:0] bx_of(input logic signed [ProdBits-1:0] p);
    logic signed [ProdBits-1:0] s;
    s = p >>> PShift;
    return AccBits'(s);
  endfunction

  // floor((hi * 2^24 + lo) / 2^30)
  function automatic logic signed [AccBits-1:0] fb_comb(
    input logic signed [ProdBits-1:0] hi,
    input logic signed [ProdBits-1:0] lo
  );
    logic signed [CombBits-1:0] full;
    logic signed [CombBits-1:0] sh;
    full = (CombBits'(hi) <<< YSplit) + CombBits'(lo);
    sh   = full >>> FbShift;
    return AccBits'(sh);
  endfunction

endpackage

`default_nettype wire

@@ design/mbq_cfg.sv @@
`default_nettype none

module mbq_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mbq_pkg::RegIdxBits-1:0] cfg_idx_i,
  input  wire logic [mbq_pkg::CoefBits-1:0]   cfg_wdata_i,
  output mbq_pkg::coef_t                      coef_o
);
  import mbq_pkg::*;

  coef_t coef_q, coef_d;

  always_comb begin
    coef_d = coef_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_B0:  coef_d.b0 = $signed(cfg_wdata_i);
        REG_B1:  coef_d.b1 = $signed(cfg_wdata_i);
        REG_B2:  coef_d.b2 = $signed(cfg_wdata_i);
        REG_A1:  coef_d.a1 = $signed(cfg_wdata_i);
        REG_A2:  coef_d.a2 = $signed(cfg_wdata_i);
        default: coef_d = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= CoefOne;
      coef_q.b1 <= '0;
      coef_q.b2 <= '0;
      coef_q.a1 <= '0;
      coef_q.a2 <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

@@ design/mbq_ctrl.sv @@
`default_nettype none

module mbq_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  mbq_pkg::status_t status_i,
  output mbq_pkg::cmd_t    cmd_o
);
  import mbq_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_B1;
      ST_B1:   state_d = ST_B2;
      ST_B2:   state_d = ST_A1H;
      ST_A1H:  state_d = ST_A1L;
      ST_A1L:  state_d = ST_A2H;
      ST_A2H:  state_d = ST_A2L;
      ST_A2L:  state_d = ST_FIN;
      ST_FIN:  state_d = ST_WR;
      ST_WR:   if (status_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE: cmd_o.op = accept ? OP_LOAD : OP_NONE;
      ST_B1:   cmd_o.op = OP_B1;
      ST_B2:   cmd_o.op = OP_B2;
      ST_A1H:  cmd_o.op = OP_A1H;
      ST_A1L:  cmd_o.op = OP_A1L;
      ST_A2H:  cmd_o.op = OP_A2H;
      ST_A2L:  cmd_o.op = OP_A2L;
      ST_FIN:  cmd_o.op = OP_FIN;
      ST_WR:   cmd_o.op = status_i.out_free ? OP_WR : OP_NONE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ design/mbq_dp.sv @@
`default_nettype none

module mbq_dp (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  mbq_pkg::in_req_t  in_req_i,
  input  mbq_pkg::coef_t    coef_i,
  input  mbq_pkg::cmd_t     cmd_i,
  output mbq_pkg::status_t  status_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output mbq_pkg::out_req_t out_req_o
);
  import mbq_pkg::*;

  logic signed [StBits-1:0]     delay_one_q [MaxChannels];
  logic signed [StBits-1:0]     delay_two_q [MaxChannels];

  logic [ChanBits-1:0]          ch_q;
  logic signed [SampleBits-1:0] x_q;
  logic signed [StBits-1:0]     d1r_q, d2r_q, y_q, d1n_q;
  logic signed [ProdBits-1:0]   prod_q, hi_q;
  logic signed [AccBits-1:0]    t1_q, t2_q, fb_q;
  logic                         clip_q;
  out_req_t                     out_q;
  logic                         out_valid_q;

  logic signed [CoefBits-1:0]   mul_a;
  logic signed [MulBBits-1:0]   mul_b, yh, yl;
  logic signed [ProdBits-1:0]   prod_d;
  logic signed [AccBits-1:0]    bx, fb_new;
  sat_t                         y_sat, d1_sat, d2_sat;
  logic signed [StBits:0]       rnd, osh;
  logic signed [SampleBits-1:0] o_val;
  logic                         o_clip;

  assign yh = MulBBits'($signed(y_q[StBits-1:YSplit]));
  assign yl = MulBBits'($signed({1'b0, y_q[YSplit-1:0]}));

  // shared multiplier operand select
  always_comb begin
    mul_a = coef_i.b0;
    mul_b = MulBBits'($signed(x_q));
    case (cmd_i.op)
      OP_LOAD: begin
        mul_a = coef_i.b0;
        mul_b = MulBBits'($signed(in_req_i.sample_in));
      end
      OP_B1:   mul_a = coef_i.b1;
      OP_B2:   mul_a = coef_i.b2;
      OP_A1H: begin
        mul_a = coef_i.a1;
        mul_b = yh;
      end
      OP_A1L: begin
        mul_a = coef_i.a1;
        mul_b = yl;
      end
      OP_A2H: begin
        mul_a = coef_i.a2;
        mul_b = yh;
      end
      OP_A2L: begin
        mul_a = coef_i.a2;
        mul_b = yl;
      end
      default: mul_a = coef_i.b0;
    endcase
  end

  assign prod_d = ProdBits'(mul_a) * ProdBits'(mul_b);

  assign bx     = bx_of(prod_q);
  assign fb_new = fb_comb(hi_q, prod_q);
  assign y_sat  = sat_st(bx + AccBits'(d1r_q));
  assign d1_sat = sat_st(t1_q - fb_q);
  assign d2_sat = sat_st(t2_q - fb_q);

  // output rounding, half up, then clamp to sample width
  always_comb begin
    rnd    = (StBits+1)'(y_q) + RndHalf;
    osh    = rnd >>> OShift;
    o_clip = 1'b0;
    o_val  = osh[SampleBits-1:0];
    if (osh > OutMax) begin
      o_clip = 1'b1;
      o_val  = OutMax[SampleBits-1:0];
    end else if (osh < OutMin) begin
      o_clip = 1'b1;
      o_val  = OutMin[SampleBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.op)
      OP_LOAD: begin
        x_q    <= in_req_i.sample_in;
        ch_q   <= in_req_i.chan;
        clip_q <= 1'b0;
        d1r_q  <= in_req_i.restart ? '0 : delay_one_q[in_req_i.chan];
        d2r_q  <= in_req_i.restart ? '0 : delay_two_q[in_req_i.chan];
      end
      OP_B1: begin
        y_q    <= y_sat.val;
        clip_q <= clip_q | y_sat.clip;
      end
      OP_B2:   t1_q <= bx + AccBits'(d2r_q);
      OP_A1H:  t2_q <= bx;
      OP_A1L:  hi_q <= prod_q;
      OP_A2H:  fb_q <= fb_new;
      OP_A2L: begin
        d1n_q  <= d1_sat.val;
        clip_q <= clip_q | d1_sat.clip;
        hi_q   <= prod_q;
      end
      OP_FIN:  fb_q <= fb_new;
      OP_WR: begin
        out_q.sample_out <= o_val;
        out_q.chan_out   <= ch_q;
        out_q.clipped    <= clip_q | d2_sat.clip | o_clip;
      end
      default: clip_q <= clip_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxChannels; i++) begin
        delay_one_q[i] <= '0;
        delay_two_q[i] <= '0;
      end
    end else begin
      if (cmd_i.op == OP_WR) begin
        out_valid_q       <= 1'b1;
        delay_one_q[ch_q] <= d1n_q;
        delay_two_q[ch_q] <= d2_sat.val;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_req_o         = out_q;

endmodule

`default_nettype wire

@@ design/multichannel_biquad_filter.sv @@
// a request runs through the B1, B2, A1H, A1L, A2H, A2L, FIN and WR states
// before its result is registered; new requests stall meanwhile, since the single
// shared 32x25 multiplier steps through the seven partial products in sequence
// the next request is taken while a finished result waits at the output
// reset: coefficients return to b0 = 1.0 and zero, all channel delay state clears
`default_nettype none

module multichannel_biquad_filter (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  mbq_pkg::in_req_t                    in_req_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output mbq_pkg::out_req_t                   out_req_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [mbq_pkg::RegIdxBits-1:0] cfg_idx_i,
  input  wire logic [mbq_pkg::CoefBits-1:0]   cfg_wdata_i
);
  import mbq_pkg::*;

  coef_t   coef;
  cmd_t    cmd;
  status_t status;

  mbq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  mbq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mbq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .coef_i      (coef),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none

module testbench;
  import mbq_pkg::*;

  localparam int WideBits = 96;
  typedef logic signed [WideBits-1:0] wide_t;

  localparam wide_t StateHi = (wide_t'(1) <<< (StBits - 1)) - 1;
  localparam wide_t StateLo = -StateHi - 1;
  localparam wide_t OutHi = (wide_t'(1) <<< (SampleBits - 1)) - 1;
  localparam wide_t OutLo = -OutHi - 1;
  localparam wide_t RoundHalf = wide_t'(1) <<< (OShift - 1);
  localparam logic [RegIdxBits-1:0] RegIdxTop = '1;

  localparam int CycleLimit = 200000;
  localparam int ItemsPerPhase = 80;
  localparam int LongHoldCycles = 400;
  localparam int LongHoldAfter = 120;
  localparam int SettleCycles = 40;
  localparam int PrintCap = 50;

  typedef enum logic {
    PLAN_WRITE,
    PLAN_SAMPLE
  } plan_kind_e;

  typedef enum int {
    COEF_ANY,
    COEF_MILD,
    COEF_EDGE,
    COEF_UNITY
  } coef_mode_e;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct packed {
    plan_kind_e                kind;
    logic [RegIdxBits-1:0]     idx;
    logic [CoefBits-1:0]       data;
    in_req_t                   req;
    logic                      typed;
    out_req_t                  want;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_req_t               in_req_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_req_t              out_req_o;
  logic                  cfg_we_i;
  logic [RegIdxBits-1:0] cfg_idx_i;
  logic [CoefBits-1:0]   cfg_wdata_i;

  coef_t                     coef_model;
  logic signed [StBits-1:0]  delay_one_model [MaxChannels];
  logic signed [StBits-1:0]  delay_two_model [MaxChannels];
  out_req_t                  pending_outputs [$];
  plan_row_t                 directed_plan [$];
  coef_mode_e                phase_modes [6] =
    '{COEF_MILD, COEF_ANY, COEF_EDGE, COEF_MILD, COEF_UNITY, COEF_ANY};
  int                        mismatch_count = 0;
  int                        results_seen = 0;
  int                        cycle_count = 0;

  multichannel_biquad_filter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic wide_t clamp_state(input wide_t v);
    if (v > StateHi) return StateHi;
    if (v < StateLo) return StateLo;
    return v;
  endfunction

  function automatic out_req_t biquad_step(input in_req_t req);
    out_req_t res;
    wide_t    x, y, d1, d2, o;
    wide_t    b0, b1, b2, a1, a2, t1, t2;
    logic     clip;
    int       ch;
    ch = req.chan;
    res.chan_out = req.chan;
    res.sample_out = '0;
    res.clipped = 1'b0;
    if (ch >= MaxChannels) return res;
    if (req.restart) begin
      delay_one_model[ch] = '0;
      delay_two_model[ch] = '0;
    end
    x  = $signed(req.sample_in);
    b0 = $signed(coef_model.b0);
    b1 = $signed(coef_model.b1);
    b2 = $signed(coef_model.b2);
    a1 = $signed(coef_model.a1);
    a2 = $signed(coef_model.a2);
    t1 = $signed(delay_one_model[ch]);
    t2 = $signed(delay_two_model[ch]);
    clip = 1'b0;
    y = ((b0 * x) >>> PShift) + t1;
    if (y != clamp_state(y)) clip = 1'b1;
    y = clamp_state(y);
    d1 = ((b1 * x) >>> PShift) - ((a1 * y) >>> FbShift) + t2;
    d2 = ((b2 * x) >>> PShift) - ((a2 * y) >>> FbShift);
    if (d1 != clamp_state(d1) || d2 != clamp_state(d2)) clip = 1'b1;
    d1 = clamp_state(d1);
    d2 = clamp_state(d2);
    delay_one_model[ch] = d1[StBits-1:0];
    delay_two_model[ch] = d2[StBits-1:0];
    o = (y + RoundHalf) >>> OShift;
    if (o > OutHi) begin
      o = OutHi;
      clip = 1'b1;
    end else if (o < OutLo) begin
      o = OutLo;
      clip = 1'b1;
    end
    res.sample_out = o[SampleBits-1:0];
    res.clipped = clip;
    return res;
  endfunction

  function automatic logic [CoefBits-1:0] pick_coef(input coef_mode_e mode);
    case (mode)
      COEF_MILD: begin
        return CoefBits'($urandom_range(0, 32'h3FFF_FFFF)) - 32'h2000_0000;
      end
      COEF_EDGE: begin
        case ($urandom_range(0, 2))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          default: return '0;
        endcase
      end
      default: begin
        return CoefBits'($urandom);
      end
    endcase
  endfunction

  function automatic in_req_t random_req();
    in_req_t req;
    case ($urandom_range(0, 7))
      0: req.sample_in = {1'b0, {(SampleBits-1){1'b1}}};
      1: req.sample_in = {1'b1, {(SampleBits-1){1'b0}}};
      2: req.sample_in = SampleBits'($urandom_range(0, 511)) - SampleBits'(256);
      default: req.sample_in = SampleBits'($urandom);
    endcase
    req.chan = ChanBits'($urandom_range(0, MaxChannels - 1));
    req.restart = ($urandom_range(0, 9) == 0);
    return req;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PrintCap) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic plan_write(input logic [RegIdxBits-1:0] idx, input logic [CoefBits-1:0] data);
    plan_row_t row;
    row = '0;
    row.kind = PLAN_WRITE;
    row.idx = idx;
    row.data = data;
    directed_plan.push_back(row);
  endtask

  task automatic plan_req(input logic [SampleBits-1:0] s, input logic [ChanBits-1:0] c,
                          input logic r, input logic typed,
                          input logic [SampleBits-1:0] want_s, input logic want_clip);
    plan_row_t row;
    row = '0;
    row.kind = PLAN_SAMPLE;
    row.req.sample_in = s;
    row.req.chan = c;
    row.req.restart = r;
    row.typed = typed;
    row.want.sample_out = want_s;
    row.want.chan_out = c;
    row.want.clipped = want_clip;
    directed_plan.push_back(row);
  endtask

  task automatic write_reg(input logic [RegIdxBits-1:0] idx, input logic [CoefBits-1:0] data);
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_B0: coef_model.b0 = data;
      REG_B1: coef_model.b1 = data;
      REG_B2: coef_model.b2 = data;
      REG_A1: coef_model.a1 = data;
      REG_A2: coef_model.a2 = data;
      default: ;
    endcase
  endtask

  task automatic send_sample(input in_req_t req, input logic typed, input out_req_t want);
    out_req_t predicted;
    cfg_we_i <= 1'b0;
    in_valid_i <= 1'b1;
    in_req_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = biquad_step(req);
    pending_outputs.push_back(typed ? want : predicted);
  endtask

  // output checker
  always @(posedge clk_i) begin
    out_req_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected result on chan %0d", out_req_o.chan_out));
      end else begin
        want = pending_outputs.pop_front();
        if (out_req_o.sample_out !== want.sample_out)
          report_mismatch($sformatf("chan %0d sample_out %0d, want %0d", want.chan_out,
                                    $signed(out_req_o.sample_out), $signed(want.sample_out)));
        if (out_req_o.chan_out !== want.chan_out)
          report_mismatch($sformatf("chan_out %0d, want %0d", out_req_o.chan_out,
                                    want.chan_out));
        if (out_req_o.clipped !== want.clipped)
          report_mismatch($sformatf("chan %0d clipped %0b, want %0b", want.chan_out,
                                    out_req_o.clipped, want.clipped));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // output stall pattern, with one long hold-off to back up the pipeline
  initial begin
    int          mode_left;
    stall_mode_e stall_mode;
    bit          held;
    out_stall_i = 1'b0;
    mode_left = 0;
    stall_mode = STALL_NONE;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= LongHoldAfter) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(STALL_NONE, STALL_PERIODIC));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= ((mode_left % 8) < 5);
      endcase
    end
  end

  initial begin
    plan_row_t             row;
    logic [CoefBits-1:0]   data;
    int                    sent;
    int                    burst;
    int                    gap;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    coef_model.b0 = CoefOne;
    coef_model.b1 = '0;
    coef_model.b2 = '0;
    coef_model.a1 = '0;
    coef_model.a2 = '0;
    for (int ch = 0; ch < MaxChannels; ch++) begin
      delay_one_model[ch] = '0;
      delay_two_model[ch] = '0;
    end

    // reset coefficients pass samples through unchanged
    plan_req(24'h7FFFFF, 3'd0, 1'b0, 1'b1, 24'h7FFFFF, 1'b0);
    plan_req(24'h800000, 3'd1, 1'b1, 1'b1, 24'h800000, 1'b0);
    plan_req(24'h000000, 3'd7, 1'b0, 1'b1, 24'h000000, 1'b0);
    plan_req(24'hFFFFFF, 3'd3, 1'b0, 1'b1, 24'hFFFFFF, 1'b0);
    plan_req(24'h000001, 3'd4, 1'b1, 1'b1, 24'h000001, 1'b0);
    plan_req(24'h555555, 3'd5, 1'b0, 1'b1, 24'h555555, 1'b0);
    plan_req(24'hAAAAAA, 3'd6, 1'b1, 1'b1, 24'hAAAAAA, 1'b0);
    // gain near +2 and -2 saturates the output
    plan_write(REG_B0, 32'h7FFF_FFFF);
    plan_req(24'h7FFFFF, 3'd2, 1'b0, 1'b1, 24'h7FFFFF, 1'b1);
    plan_req(24'h800000, 3'd5, 1'b0, 1'b1, 24'h800000, 1'b1);
    plan_write(REG_B0, 32'h8000_0000);
    plan_req(24'h800000, 3'd6, 1'b0, 1'b1, 24'h7FFFFF, 1'b1);
    plan_req(24'h7FFFFF, 3'd0, 1'b0, 1'b1, 24'h800000, 1'b1);
    // writes to unused indexes are dropped
    plan_write(RegIdxBits'(REG_A2 + 1), 32'hFFFF_FFFF);
    plan_write(RegIdxTop, 32'hFFFF_FFFF);
    // gain of -2 on zero, small positive and small negative samples
    plan_req(24'h000000, 3'd1, 1'b0, 1'b1, 24'h000000, 1'b0);
    plan_req(24'h000001, 3'd1, 1'b0, 1'b1, 24'hFFFFFE, 1'b0);
    plan_req(24'hFFFFFF, 3'd3, 1'b0, 1'b1, 24'h000002, 1'b0);
    // low-pass section
    plan_write(REG_B0, 32'h0400_0000);
    plan_write(REG_B1, 32'h0800_0000);
    plan_write(REG_B2, 32'h0400_0000);
    plan_write(REG_A1, 32'hA000_0000);
    plan_write(REG_A2, 32'h28F5_C28F);
    plan_req(24'h400000, 3'd0, 1'b1, 1'b0, '0, 1'b0);
    plan_req(24'h400000, 3'd0, 1'b0, 1'b0, '0, 1'b0);
    plan_req(24'hC00000, 3'd0, 1'b0, 1'b0, '0, 1'b0);
    plan_req(24'h7FFFFF, 3'd2, 1'b0, 1'b0, '0, 1'b0);
    plan_req(24'h000000, 3'd0, 1'b1, 1'b0, '0, 1'b0);
    // runaway feedback drives the delay state into saturation
    plan_write(REG_B0, 32'h7FFF_FFFF);
    plan_write(REG_B1, 32'h7FFF_FFFF);
    plan_write(REG_B2, 32'h7FFF_FFFF);
    plan_write(REG_A1, 32'h8000_0000);
    plan_write(REG_A2, 32'h8000_0000);
    plan_req(24'h7FFFFF, 3'd1, 1'b1, 1'b0, '0, 1'b0);
    plan_req(24'h7FFFFF, 3'd1, 1'b0, 1'b0, '0, 1'b0);
    plan_req(24'h7FFFFF, 3'd1, 1'b0, 1'b0, '0, 1'b0);
    plan_req(24'h7FFFFF, 3'd1, 1'b0, 1'b0, '0, 1'b0);
    plan_req(24'h800000, 3'd1, 1'b0, 1'b0, '0, 1'b0);
    plan_req(24'h800000, 3'd1, 1'b1, 1'b0, '0, 1'b0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == PLAN_WRITE) begin
        write_reg(row.idx, row.data);
      end else begin
        send_sample(row.req, row.typed, row.want);
      end
    end

    foreach (phase_modes[p]) begin
      for (int r = REG_B0; r <= REG_A2; r++) begin
        if (phase_modes[p] == COEF_UNITY) begin
          data = (r == REG_B0) ? CoefOne : '0;
        end else begin
          data = pick_coef(phase_modes[p]);
        end
        write_reg(RegIdxBits'(r), data);
      end
      write_reg(RegIdxBits'($urandom_range(REG_A2 + 1, RegIdxTop)), CoefBits'($urandom));
      sent = 0;
      while (sent < ItemsPerPhase) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < ItemsPerPhase; k++) begin
          send_sample(random_req(), 1'b0, '0);
          sent++;
        end
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
